// ----- hdl/ofr_pkg.sv -----
// Shared types and constants for the overwriting ring FIFO.
`default_nettype none

package ofr_pkg;

    localparam int CNT_W       = 5;
    localparam int ACT_W       = 3;
    localparam int DEPTH_RESET = 16;

    typedef logic [CNT_W-1:0] t_count;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH    = 3'd0,
        ACT_RESERVE = 3'd1,
        ACT_COMMIT  = 3'd2,
        ACT_PEEK    = 3'd3,
        ACT_POP     = 3'd4
    } t_action;

endpackage

`default_nettype wire

// ----- hdl/ofr_ifs.sv -----
// Handshake channels of the overwriting ring FIFO: request, result and depth write.
`default_nettype none

interface ofr_in_if
    import ofr_pkg::*;
#(
    parameter int ENTRY_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [ACT_W-1:0]      action;
    logic [ENTRY_BITS-1:0] data_in;

    modport source (output valid, input ready, output action, output data_in);
    modport sink   (input valid, output ready, input action, input data_in);
endinterface

interface ofr_out_if
    import ofr_pkg::*;
#(
    parameter int ENTRY_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  status;
    logic [ENTRY_BITS-1:0] data_out;
    logic [CNT_W-1:0]      entry_count;
    logic                  reserved_flag;

    modport source (output valid, input ready, output status, output data_out,
                    output entry_count, output reserved_flag);
    modport sink   (input valid, output ready, input status, input data_out,
                    input entry_count, input reserved_flag);
endinterface

interface ofr_cfg_if
    import ofr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] depth_in_use;

    modport source (output valid, input ready, output depth_in_use);
    modport sink   (input valid, output ready, input depth_in_use);
endinterface

`default_nettype wire

// ----- hdl/overwrite_ring_fifo_with_reserve.sv -----
// Top level of the overwriting ring FIFO with a one-slot tail reservation.
// The result word is registered and appears in the cycle after its request word is taken.
// Throughput: one request word per cycle while the result is not stalled; the entry RAM is read
// and written at the acceptance edge and its registered read port drives the result data directly.
// Reset: ring empty, no reservation, depth 16 (or MAX_DEPTH if smaller); the entry
// store is not cleared, every entry is written before it can be read.
`default_nettype none

module overwrite_ring_fifo_with_reserve
    import ofr_pkg::*;
#(
    parameter int MAX_DEPTH  = 16,
    parameter int ENTRY_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ofr_cfg_if.sink    i_cfg,
    ofr_in_if.sink     i_in,
    ofr_out_if.source  o_out
);

    localparam int IDX_W = $clog2(MAX_DEPTH);
    localparam int CMP_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam logic [CMP_W-1:0] MAX_D = CMP_W'(MAX_DEPTH);
    localparam t_count DEPTH_RST = (CMP_W'(DEPTH_RESET) > MAX_D) ?
                                   CNT_W'(MAX_DEPTH) : CNT_W'(DEPTH_RESET);

    // ring state
    t_count           r_depth;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    t_count           r_count, n_count;
    logic             r_resv, n_resv;

    // result register
    logic             r_out_valid;
    logic             r_o_status;
    t_count           r_o_count;
    logic             r_o_resv;
    logic             r_o_read;

    logic             acc;
    logic             ok;
    logic             wr;
    logic             rd;
    logic             full;
    logic [ENTRY_BITS-1:0] rdata;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                  input t_count depth);
        logic [CMP_W-1:0] inc;
        inc = CMP_W'(idx) + CMP_W'(1);
        return (inc >= CMP_W'(depth)) ? '0 : inc[IDX_W-1:0];
    endfunction

    function automatic t_count clamp_depth(input t_count v);
        t_count d;
        if (v == '0) begin
            d = CNT_W'(1);
        end else if (CMP_W'(v) > MAX_D) begin
            d = CNT_W'(MAX_DEPTH);
        end else begin
            d = v;
        end
        return d;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign acc         = i_in.valid && i_in.ready;
    assign full        = r_count >= r_depth;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_resv  = r_resv;
        ok      = 1'b0;
        wr      = 1'b0;
        rd      = 1'b0;
        case (i_in.action)
            ACT_PUSH: begin
                // a full ring loses its oldest word even when the push is refused
                if (full) begin
                    n_head  = next_idx(r_head, r_depth);
                    n_count = r_count - CNT_W'(1);
                end
                if (!r_resv) begin
                    wr      = 1'b1;
                    n_tail  = next_idx(r_tail, r_depth);
                    n_count = n_count + CNT_W'(1);
                    ok      = 1'b1;
                end
            end
            ACT_RESERVE: begin
                if (!r_resv) begin
                    if (full) begin
                        n_head  = next_idx(r_head, r_depth);
                        n_count = r_count - CNT_W'(1);
                    end
                    n_resv = 1'b1;
                    ok     = 1'b1;
                end
            end
            ACT_COMMIT: begin
                if (r_resv) begin
                    wr      = 1'b1;
                    n_tail  = next_idx(r_tail, r_depth);
                    n_count = r_count + CNT_W'(1);
                    n_resv  = 1'b0;
                    ok      = 1'b1;
                end
            end
            ACT_PEEK, ACT_POP: begin
                if (r_count != '0) begin
                    rd = 1'b1;
                    ok = 1'b1;
                    if (i_in.action == ACT_POP) begin
                        n_head  = next_idx(r_head, r_depth);
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    ofr_ram #(
        .DEPTH (MAX_DEPTH),
        .WIDTH (ENTRY_BITS)
    ) u_ofr_ram (
        .i_clk   (i_clk),
        .i_we    (acc && wr),
        .i_waddr (r_tail),
        .i_wdata (i_in.data_in),
        .i_re    (acc && rd),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= DEPTH_RST;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_resv      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                // a depth write empties the ring
                r_depth <= clamp_depth(i_cfg.depth_in_use);
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
                r_resv  <= 1'b0;
            end else if (acc) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_resv  <= n_resv;
            end
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; RAM read data holds on its own while no word is taken
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_o_status <= !ok;
            r_o_count  <= n_count;
            r_o_resv   <= n_resv;
            r_o_read   <= rd;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_o_status;
    assign o_out.data_out      = r_o_read ? rdata : '0;
    assign o_out.entry_count   = r_o_count;
    assign o_out.reserved_flag = r_o_resv;

endmodule

`default_nettype wire

// ----- hdl/ofr_ram.sv -----
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module ofr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ofr_checker.sv -----
// Port-level checks for the overwriting ring FIFO, bound to the top level.
`default_nettype none

module ofr_checker
    import ofr_pkg::*;
#(
    parameter int MAX_DEPTH  = 16,
    parameter int ENTRY_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic                  i_status,
    input  wire logic [ENTRY_BITS-1:0] i_data_out,
    input  wire logic [CNT_W-1:0]      i_entry_count,
    input  wire logic                  i_reserved_flag
);

    // every accepted request word yields a result word in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("no result after accepted request");

    // a failed action never returns data
    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_data_out == '0)
        else $error("data returned with error status");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_entry_count) <= MAX_DEPTH)
        else $error("entry count above built depth");

    // a reserved slot always leaves at least one slot free
    a_reserve_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_reserved_flag |-> 32'(i_entry_count) < MAX_DEPTH)
        else $error("ring full while a slot is reserved");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_data_out) && $stable(i_entry_count) && $stable(i_reserved_flag))
        else $error("result word changed while stalled");

endmodule

bind overwrite_ring_fifo_with_reserve ofr_checker #(
    .MAX_DEPTH  (MAX_DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
) u_ofr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_status        (o_out.status),
    .i_data_out      (o_out.data_out),
    .i_entry_count   (o_out.entry_count),
    .i_reserved_flag (o_out.reserved_flag)
);

`default_nettype wire
